>>> sv/sqcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcf_pkg
// Shared types and codes for the square-root continued fraction term block.
// ----------------------------------------------------------------------------
package sqcf_pkg;

    // request command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_TERM   = 2'd0;
    localparam logic [1:0] ST_PERIOD = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    localparam int          PERIOD_W   = 32;
    localparam logic [31:0] PERIOD_MAX = 32'hFFFF_FFFF;

    // operations of the shared iterative unit
    typedef enum logic [1:0] {
        MODE_SQRT       = 2'd0,
        MODE_DIV_WIDE   = 2'd1,
        MODE_DIV_NARROW = 2'd2
    } t_unit_mode;

    typedef struct packed {
        logic       start;
        t_unit_mode mode;
    } t_unit_req;

endpackage

>>> sv/sqcf_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcf_unit
// Shared restoring unit: one subtract/compare per cycle, running either an
// integer square root (two bits per step) or a division (one bit per step).
// ----------------------------------------------------------------------------
module sqcf_unit
    import sqcf_pkg::*;
#(
    parameter int  NUMBER_WIDTH = 32,
    localparam int RW = (NUMBER_WIDTH + 1) / 2,
    localparam int TW = RW + 1,
    localparam int SW = RW + 2,
    localparam int XW = 2 * RW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_unit_req     i_req,
    input  logic [XW-1:0] i_operand,
    input  logic [TW-1:0] i_divisor,
    output logic          o_done,
    output logic [TW-1:0] o_quot,
    output logic [SW-1:0] o_rem
);

    localparam int CW = $clog2(XW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    t_unit_mode    r_mode;
    logic [XW-1:0] r_x;
    logic [TW-1:0] r_quot;
    logic [SW-1:0] r_rem;
    logic [TW-1:0] r_div;

    logic [CW-1:0] w_count;
    logic [SW-1:0] w_shift;
    logic [SW-1:0] w_sub_b;
    logic [SW:0]   w_diff;
    logic          w_take;

    always_comb begin
        unique case (i_req.mode)
            MODE_SQRT:       w_count = CW'(RW);
            MODE_DIV_WIDE:   w_count = CW'(NUMBER_WIDTH);
            MODE_DIV_NARROW: w_count = CW'(TW);
            default:         w_count = CW'(TW);
        endcase
    end

    // square root: trial is (root << 2) | 1; division: trial is the divisor
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            w_shift = {r_rem[SW-3:0], r_x[XW-1:XW-2]};
            w_sub_b = {r_quot[RW-1:0], 2'b01};
        end else begin
            w_shift = {r_rem[SW-2:0], r_x[XW-1]};
            w_sub_b = SW'(r_div);
        end
        w_diff = {1'b0, w_shift} - {1'b0, w_sub_b};
        w_take = ~w_diff[SW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= MODE_SQRT;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= w_count;
            r_mode <= i_req.mode;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_operand;
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_take ? w_diff[SW-1:0] : w_shift;
            r_quot <= {r_quot[TW-2:0], w_take};
            r_x    <= (r_mode == MODE_SQRT) ? (r_x << 2) : (r_x << 1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> sv/sqrt_continued_fraction_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrt_continued_fraction_terms
// Returns the periodic continued fraction of sqrt(N), one partial quotient
// per request, and the period length once the expansion repeats.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_cmd, i_number
//  result    out        o_out_valid / i_out_ready  o_status, o_term, o_period
//
//  Start runs the square root through the shared unit two bits at a time.
//  Next runs one squaring, then two restoring divisions on the same unit,
//  one bit per cycle. Status-only answers (no number, period done) skip
//  the shared unit and go straight to waiting for the output slot.
//  Reset is synchronous, active low; the expansion state returns to idle.
//  A finished result waits in the output register; a new request is taken
//  meanwhile, and its result holds until the output slot frees.
// ----------------------------------------------------------------------------
module sqrt_continued_fraction_terms
    import sqcf_pkg::*;
#(
    parameter int  NUMBER_WIDTH = 32,
    localparam int RW = (NUMBER_WIDTH + 1) / 2,
    localparam int TW = RW + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_cmd,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [TW-1:0]           o_term,
    output logic [PERIOD_W-1:0]     o_period
);

    localparam int SW = RW + 2;
    localparam int XW = 2 * RW;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ROOT = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_SUB  = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FIRST = 4'b0010,
        PH_RUN   = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [NUMBER_WIDTH-1:0] r_num;
    logic [NUMBER_WIDTH-1:0] r_radicand;
    logic [RW-1:0]           r_root;
    logic [TW-1:0]           r_rem;
    logic [TW-1:0]           r_denom;
    logic [TW-1:0]           r_first_rem;
    logic [TW-1:0]           r_first_denom;
    logic [PERIOD_W-1:0]     r_count;
    logic [2*RW-1:0]         r_square;
    logic [TW-1:0]           r_nd;

    logic [1:0]              r_pend_status;
    logic [TW-1:0]           r_pend_term;
    logic [PERIOD_W-1:0]     r_pend_period;

    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [TW-1:0]           r_term;
    logic [PERIOD_W-1:0]     r_period;

    t_unit_req               w_req;
    logic [XW-1:0]           w_operand;
    logic [TW-1:0]           w_divisor;
    logic                    w_done;
    logic [TW-1:0]           w_quot;
    logic [SW-1:0]           w_urem;

    logic                    w_accept;
    logic [TW-1:0]           w_m;
    logic [TW-1:0]           w_top;
    logic [NUMBER_WIDTH-1:0] w_residue;
    logic [TW-1:0]           w_nd;
    logic [TW-1:0]           w_new_rem;
    logic                    w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_m        = TW'(r_root) - r_rem;
    assign w_top      = {r_root, 1'b0} - r_rem;
    assign w_residue  = r_radicand - r_square[NUMBER_WIDTH-1:0];
    assign w_nd       = (w_quot == '0) ? TW'(1) : w_quot;
    assign w_new_rem  = w_urem[TW-1:0];

    sqcf_unit #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_operand (w_operand),
        .i_divisor (w_divisor),
        .o_done    (w_done),
        .o_quot    (w_quot),
        .o_rem     (w_urem)
    );

    // launch the shared unit
    always_comb begin
        w_req.start = 1'b0;
        w_req.mode  = MODE_SQRT;
        w_operand   = XW'(i_number);
        w_divisor   = r_denom;
        priority if (r_state == S_IDLE && w_accept && i_cmd == CMD_START) begin
            w_req.start = 1'b1;
        end else if (r_state == S_SUB) begin
            w_req.start = 1'b1;
            w_req.mode  = MODE_DIV_WIDE;
            w_operand   = XW'(w_residue) << (XW - NUMBER_WIDTH);
            w_divisor   = (r_denom == '0) ? TW'(1) : r_denom;
        end else if (r_state == S_DIV1 && w_done) begin
            w_req.start = 1'b1;
            w_req.mode  = MODE_DIV_NARROW;
            w_operand   = XW'(w_top) << (XW - TW);
            w_divisor   = w_nd;
        end else begin
            w_req.start = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_START) begin
                        n_state = S_ROOT;
                    end else if (r_phase == PH_FIRST || r_phase == PH_RUN) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_ROOT:  if (w_done) n_state = S_WAIT;
            S_MUL:   n_state = S_SUB;
            S_SUB:   n_state = S_DIV1;
            S_DIV1:  if (w_done) n_state = S_DIV2;
            S_DIV2:  if (w_done) n_state = S_WAIT;
            S_WAIT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // expansion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_radicand    <= '0;
            r_root        <= '0;
            r_rem         <= '0;
            r_denom       <= TW'(1);
            r_first_rem   <= '0;
            r_first_denom <= TW'(1);
            r_count       <= '0;
        end else begin
            if (r_state == S_ROOT && w_done) begin
                if (w_urem == '0) begin
                    r_phase <= PH_IDLE;
                end else begin
                    r_radicand <= r_num;
                    r_root     <= w_quot[RW-1:0];
                    r_rem      <= '0;
                    r_denom    <= TW'(1);
                    r_count    <= '0;
                    r_phase    <= PH_FIRST;
                end
            end
            if (r_state == S_DIV2 && w_done) begin
                r_rem   <= w_new_rem;
                r_denom <= r_nd;
                if (r_phase == PH_FIRST) begin
                    r_first_rem   <= w_new_rem;
                    r_first_denom <= r_nd;
                    r_count       <= PERIOD_W'(1);
                    r_phase       <= PH_RUN;
                end else if (w_new_rem == r_first_rem && r_nd == r_first_denom) begin
                    r_phase <= PH_DONE;
                end else if (r_count != PERIOD_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // operands and the pending result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_num         <= i_number;
            r_pend_status <= ST_TERM;
            r_pend_term   <= '0;
            r_pend_period <= '0;
            if (i_cmd == CMD_NEXT) begin
                if (r_phase == PH_DONE) begin
                    r_pend_status <= ST_PERIOD;
                    r_pend_period <= r_count;
                end else if (r_phase == PH_IDLE) begin
                    r_pend_status <= ST_IDLE;
                end
            end
        end
        if (r_state == S_MUL) begin
            r_square <= w_m[RW-1:0] * w_m[RW-1:0];
        end
        if (r_state == S_DIV1 && w_done) begin
            r_nd <= w_nd;
        end
        if (r_state == S_ROOT && w_done) begin
            if (w_urem == '0) begin
                r_pend_status <= ST_REJECT;
            end else begin
                r_pend_term <= TW'(w_quot[RW-1:0]);
            end
        end
        if (r_state == S_DIV2 && w_done) begin
            if (r_phase == PH_RUN && w_new_rem == r_first_rem && r_nd == r_first_denom)
            begin
                r_pend_status <= ST_PERIOD;
                r_pend_period <= r_count;
            end else begin
                r_pend_term <= w_quot;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_WAIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_out_free) begin
            r_status <= r_pend_status;
            r_term   <= r_pend_term;
            r_period <= r_pend_period;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_term      = r_term;
    assign o_period    = r_period;

endmodule

>>> sv/sqcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcf_checker
// Port-level checks for the continued fraction term block.
// ----------------------------------------------------------------------------
module sqcf_checker
    import sqcf_pkg::*;
#(
    parameter int  NUMBER_WIDTH = 32,
    localparam int RW = (NUMBER_WIDTH + 1) / 2,
    localparam int TW = RW + 1
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_cmd,
    input logic [NUMBER_WIDTH-1:0] i_number,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [1:0]              o_status,
    input logic [TW-1:0]           o_term,
    input logic [PERIOD_W-1:0]     o_period
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_term) && $stable(o_period))
        else $error("stalled result changed");

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_TERM |-> o_term == '0)
        else $error("term set on a status answer");

    a_period_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_PERIOD |-> o_period == '0)
        else $error("period set outside period complete");

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_PERIOD |-> o_period != '0)
        else $error("period complete with zero length");

endmodule

bind sqrt_continued_fraction_terms sqcf_checker #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
) u_sqcf_checker (.*);
